// ===== rtl/aeske_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 key expansion package
// Shared types, constants, the S-box function and the round-key helpers.
// ----------------------------------------------------------------------------
package aeske_pkg;

    localparam int KEY_W     = 128;
    localparam int ROUND_W   = 4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;
    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] POLY_LOW   = 8'h1B;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef logic [KEY_W-1:0] key_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
            8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
            8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
            8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
            8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
            8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
            8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
            8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
            8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
            8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
            8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
            8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
            8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
            8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
            8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
            8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
            8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
            8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
            8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
            8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
            8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
            8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
            8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
            8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
            8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
            8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
            8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
            8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
            8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
            8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
            8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
            8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
            8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
            8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
            8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
            8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
            8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
            8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
            8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
            8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
            8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
            8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
            8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
            8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
            8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
            8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
            8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
            8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
            8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
            8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
            8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
            8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
            8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? POLY_LOW : 8'h00);
    endfunction

    function automatic key_t next_round_key(input key_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, rw, g;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        rw = {w3[23:0], w3[31:24]};
        g  = {sbox(rw[31:24]) ^ rc, sbox(rw[23:16]), sbox(rw[15:8]), sbox(rw[7:0])};
        w0 = w0 ^ g;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== rtl/aeske_key_queue.sv =====
// ----------------------------------------------------------------------------
// Key queue
// Two-entry queue that takes cipher keys and holds them for the round unit.
// ----------------------------------------------------------------------------
module aeske_key_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aeske_pkg::key_t   in_key,
    output logic              out_valid,
    input  logic              out_ready,
    output aeske_pkg::key_t   out_key
);
    import aeske_pkg::*;

    key_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push, pop;

    assign in_ready  = (count_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_key   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("key queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("key queue push not counted");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("key queue pop not counted");

endmodule

// ===== rtl/aeske_round_unit.sv =====
// ----------------------------------------------------------------------------
// Round unit
// Emits the eleven round keys of one cipher key, one per cycle while the
// output is ready, through an output register.
// ----------------------------------------------------------------------------
module aeske_round_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           key_valid,
    output logic                           key_ready,
    input  aeske_pkg::key_t                key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [aeske_pkg::ROUND_W-1:0]  out_round,
    output aeske_pkg::key_t                out_key,
    output logic                           out_last
);
    import aeske_pkg::*;

    logic                 out_valid_reg;
    logic [ROUND_W-1:0]   round_reg;
    key_t                 key_reg;
    logic [7:0]           rcon_reg;
    logic                 advance, busy, load;

    assign out_valid = out_valid_reg;
    assign out_round = round_reg;
    assign out_key   = key_reg;
    assign out_last  = (round_reg == LAST_ROUND);
    assign advance   = !out_valid_reg || out_ready;
    assign busy      = out_valid_reg && !out_last;
    assign key_ready = advance && !busy;
    assign load      = key_valid && key_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
            rcon_reg      <= RCON_FIRST;
            key_reg       <= '0;
        end
        else if (advance)
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                round_reg     <= '0;
                rcon_reg      <= RCON_FIRST;
                key_reg       <= key;
            end
            else if (busy)
            begin
                round_reg <= round_reg + 1'b1;
                rcon_reg  <= gf_double(rcon_reg);
                key_reg   <= next_round_key(key_reg, rcon_reg);
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= LAST_ROUND)
        else $error("round count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(key_reg) && $stable(round_reg)))
        else $error("stalled round key changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !out_last) |=>
        (out_valid_reg && round_reg == $past(round_reg) + 1'b1))
        else $error("round sequence broken");

endmodule

// ===== rtl/aes128_key_expansion.sv =====
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Takes one cipher key per request and emits the eleven round keys.
// ----------------------------------------------------------------------------
// Each accepted key yields eleven round keys, rounds 0 to 10, one per cycle
// while the output is ready; the next key is taken as round 10 is taken. The
// rate is set by the single round unit, which forms one round key a cycle. A
// two-entry key queue in front takes the next keys while a run is in flight.
module aes128_key_expansion
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key_high[63:0], key_low[127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // round_index[3:0], round_key_high[67:4],
                                         // round_key_low[131:68], zero[135:132]
    output logic         m_axis_tlast
);
    import aeske_pkg::*;

    logic               q_valid, q_ready;
    key_t               q_key, out_key;
    logic [ROUND_W-1:0] out_round;

    aeske_key_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_key    ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_key   (q_key)
    );

    aeske_round_unit u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (q_valid),
        .key_ready (q_ready),
        .key       (q_key),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_round (out_round),
        .out_key   (out_key),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, out_key[63:0], out_key[127:64], out_round};

endmodule
